// ===== rtl/mlpf_pkg.sv =====
// Shared constants, types and codes for the multilevel priority FIFO.
`default_nettype none
package mlpf_pkg;

   localparam int NUM_LEVELS   = 16;
   localparam int CAPACITY     = 64;
   localparam int PAYLOAD_BITS = 32;

   localparam int CMD_W     = 2;
   localparam int DATA_W    = 32;
   localparam int PRIO_W    = 5;
   localparam int STATUS_W  = 2;
   localparam int LVL_W     = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int SLOT_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int CMP_W     = (LVL_W + 1 > PRIO_W) ? LVL_W + 1 : PRIO_W;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PROBE  = 2'd2;

   localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STS_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STS_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] STS_BAD_PRIO = 2'd3;

   typedef logic [LVL_W-1:0]  lvl_idx_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [PRIO_W-1:0] prio_type;

   // Carried from cell to cell along the level row.
   typedef struct packed {
      logic        higher;        // a nonempty level above the request exists
      logic        found;         // first nonempty level already seen
      slot_type    head;          // head slot of the first nonempty level
      lvl_idx_type lvl;           // index of the first nonempty level
      slot_type    tgt_tail;      // tail slot of the requested level
      logic        tgt_nonempty;  // requested level holds entries
   } chain_type;

   // Commit broadcast to every cell.
   typedef struct packed {
      logic        ins;
      logic        rem;
      lvl_idx_type lvl;
      slot_type    slot;
      slot_type    next_head;
   } upd_type;

endpackage
`default_nettype wire

// ===== rtl/mlpf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mlpf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/mlpf_level_cell.sv =====
// One priority level: head, tail and count, plus its stage of the level chain.
`default_nettype none
module mlpf_level_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mlpf_pkg::lvl_idx_type cell_idx,
   input  wire mlpf_pkg::prio_type   prio,
   input  wire mlpf_pkg::lvl_idx_type tgt_lvl,
   input  wire mlpf_pkg::chain_type  chain_in,
   output mlpf_pkg::chain_type       chain_out,
   input  wire mlpf_pkg::upd_type    upd
);
   import mlpf_pkg::*;

   slot_type head_ff;
   slot_type tail_ff;
   cnt_type  count_ff;
   logic     nonempty;
   logic     above;
   logic     hit;

   assign nonempty = (count_ff != '0);
   assign above    = (prio != '0) &&
                     (CMP_W'(cell_idx) < (CMP_W'(prio) - CMP_W'(1)));
   assign hit      = (cell_idx == upd.lvl);

   always_comb begin
      chain_out        = chain_in;
      chain_out.higher = chain_in.higher | (nonempty & above);
      if (!chain_in.found && nonempty) begin
         chain_out.found = 1'b1;
         chain_out.head  = head_ff;
         chain_out.lvl   = cell_idx;
      end
      if (cell_idx == tgt_lvl) begin
         chain_out.tgt_tail     = tail_ff;
         chain_out.tgt_nonempty = nonempty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (upd.ins && hit) begin
         count_ff <= count_ff + CNT_W'(1);
      end else if (upd.rem && hit) begin
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (upd.ins && hit) begin
         if (!nonempty) begin
            head_ff <= upd.slot;
         end
         tail_ff <= upd.slot;
      end else if (upd.rem && hit) begin
         head_ff <= upd.next_head;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/multilevel_priority_fifo_core.sv =====
// Multilevel priority FIFO: level cell row, linked slot pool and sequencer.
//
//   channel   ports                                    handshake
//   request   req_command, req_payload, req_priority_req  start & !busy
//   response  rsp_status, rsp_removed_payload,           rsp_strobe, one cycle
//             rsp_higher_waiting, rsp_occupancy
//
// Each request passes through a lookup state that walks the level row and
// reads the slot pool, then a commit state that writes the pool and the cells.
// busy is high only during lookup, so a new request can be taken while the
// last one is in commit or while idle. The response appears in the
// cycle after commit. Synchronous reset empties all levels at once; there is
// no clearing pass. The receiver cannot stall responses.
`default_nettype none
module multilevel_priority_fifo_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [mlpf_pkg::CMD_W-1:0]    req_command,
   input  wire logic [mlpf_pkg::DATA_W-1:0]   req_payload,
   input  wire logic [mlpf_pkg::PRIO_W-1:0]   req_priority_req,
   output logic                               rsp_strobe,
   output logic [mlpf_pkg::STATUS_W-1:0]      rsp_status,
   output logic [mlpf_pkg::DATA_W-1:0]        rsp_removed_payload,
   output logic                               rsp_higher_waiting,
   output logic [mlpf_pkg::CNT_W-1:0]         rsp_occupancy
);
   import mlpf_pkg::*;

   localparam logic [1:0] STATE_IDLE   = 2'd0;
   localparam logic [1:0] STATE_LOOKUP = 2'd1;
   localparam logic [1:0] STATE_COMMIT = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CMD_W-1:0]  cmd_ff;
   logic [DATA_W-1:0] payload_ff;
   prio_type          prio_ff;

   // lookup decisions
   logic              ins_ff, rem_ff;
   lvl_idx_type       lvl_ff;
   slot_type          head_ff, tail_ff;
   logic              tgt_nonempty_ff;
   logic [STATUS_W-1:0] status_ff;
   logic              higher_ff;

   // pool bookkeeping
   slot_type          free_head_ff, free_head_in;
   cnt_type           fill_ff, fill_in;
   cnt_type           total_ff, total_in;

   // response registers
   logic              rsp_strobe_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [DATA_W-1:0] rsp_removed_ff;
   logic              rsp_higher_ff;
   cnt_type           rsp_occ_ff;

   chain_type         chain [NUM_LEVELS+1];
   upd_type           upd;
   lvl_idx_type       tgt_lvl;
   logic              prio_ok;
   logic              accept;
   logic              free_avail;
   slot_type          alloc_slot;

   logic [PAYLOAD_BITS-1:0] pay_rdata;
   slot_type          link_rdata;
   logic              link_we;
   slot_type          link_waddr, link_wdata, link_raddr;
   logic              pay_we;

   logic              ins_in, rem_in;
   logic [STATUS_W-1:0] status_in;

   assign busy    = (state_ff == STATE_LOOKUP);
   assign accept  = start && !busy;
   assign prio_ok = (prio_ff != '0) && (prio_ff <= PRIO_W'(NUM_LEVELS));
   assign tgt_lvl = LVL_W'(prio_ff - PRIO_W'(1));

   // ---------------- level row ----------------
   assign chain[0] = '0;

   for (genvar i = 0; i < NUM_LEVELS; i++) begin : g_cell
      mlpf_level_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (LVL_W'(i)),
         .prio      (prio_ff),
         .tgt_lvl   (tgt_lvl),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1]),
         .upd       (upd)
      );
   end

   // ---------------- sequencer ----------------
   always_comb begin
      unique case (state_ff)
         STATE_LOOKUP: state_in = STATE_COMMIT;
         default:      state_in = accept ? STATE_LOOKUP : STATE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= req_command;
         payload_ff <= req_payload;
         prio_ff    <= req_priority_req;
      end
   end

   // Decide the operation from the state before the step.
   always_comb begin
      ins_in    = 1'b0;
      rem_in    = 1'b0;
      status_in = STS_OK;
      unique case (cmd_ff)
         CMD_INSERT: begin
            if (!prio_ok) begin
               status_in = STS_BAD_PRIO;
            end else if (total_ff == CNT_W'(CAPACITY)) begin
               status_in = STS_FULL;
            end else begin
               ins_in = 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (!chain[NUM_LEVELS].found) begin
               status_in = STS_EMPTY;
            end else begin
               rem_in = 1'b1;
            end
         end
         default: begin
            if (!prio_ok) begin
               status_in = STS_BAD_PRIO;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ins_ff <= 1'b0;
         rem_ff <= 1'b0;
      end else if (state_ff == STATE_LOOKUP) begin
         ins_ff <= ins_in;
         rem_ff <= rem_in;
      end else begin
         ins_ff <= 1'b0;
         rem_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == STATE_LOOKUP) begin
         lvl_ff          <= rem_in ? chain[NUM_LEVELS].lvl : tgt_lvl;
         head_ff         <= chain[NUM_LEVELS].head;
         tail_ff         <= chain[NUM_LEVELS].tgt_tail;
         tgt_nonempty_ff <= chain[NUM_LEVELS].tgt_nonempty;
         status_ff       <= status_in;
         higher_ff       <= chain[NUM_LEVELS].higher;
      end
   end

   // ---------------- slot pool ----------------
   // Freed slots are chained through the link store; slots never used yet
   // come from the fill counter.
   assign free_avail = (fill_ff != total_ff);
   assign alloc_slot = free_avail ? free_head_ff : SLOT_W'(fill_ff);
   assign link_raddr = (cmd_ff == CMD_REMOVE) ? chain[NUM_LEVELS].head : free_head_ff;

   assign pay_we     = ins_ff;
   assign link_we    = (ins_ff && tgt_nonempty_ff) || rem_ff;
   assign link_waddr = rem_ff ? head_ff : tail_ff;
   assign link_wdata = rem_ff ? free_head_ff : alloc_slot;

   mlpf_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(CAPACITY)) u_payload_ram (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (alloc_slot),
      .wr_data (payload_ff[PAYLOAD_BITS-1:0]),
      .rd_addr (chain[NUM_LEVELS].head),
      .rd_data (pay_rdata)
   );

   mlpf_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   always_comb begin
      upd.ins       = ins_ff;
      upd.rem       = rem_ff;
      upd.lvl       = lvl_ff;
      upd.slot      = alloc_slot;
      upd.next_head = link_rdata;
   end

   always_comb begin
      free_head_in = free_head_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      if (ins_ff) begin
         total_in = total_ff + CNT_W'(1);
         if (free_avail) begin
            free_head_in = link_rdata;
         end else begin
            fill_in = fill_ff + CNT_W'(1);
         end
      end else if (rem_ff) begin
         total_in     = total_ff - CNT_W'(1);
         free_head_in = head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         total_ff <= '0;
      end else begin
         fill_ff  <= fill_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      free_head_ff <= free_head_in;
   end

   // ---------------- response ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == STATE_COMMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == STATE_COMMIT) begin
         rsp_status_ff  <= status_ff;
         rsp_removed_ff <= rem_ff ? DATA_W'(pay_rdata) : '0;
         rsp_higher_ff  <= higher_ff;
         rsp_occ_ff     <= total_in;
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_removed_payload = rsp_removed_ff;
   assign rsp_higher_waiting  = rsp_higher_ff;
   assign rsp_occupancy       = rsp_occ_ff;

   // ---------------- assertions ----------------
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(CAPACITY))
      else $error("occupancy exceeds pool capacity");

   a_fill_covers_total: assert property (@(posedge clock) disable iff (reset)
      fill_ff >= total_ff)
      else $error("fill counter below occupancy");

   a_strobe_after_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == STATE_COMMIT))
      else $error("response without a commit cycle");

   a_single_action: assert property (@(posedge clock) disable iff (reset)
      !(ins_ff && rem_ff))
      else $error("insert and remove committed together");

endmodule
`default_nettype wire
